// ===== hw/rtl/pn2d_pkg.sv =====
// Shared constants and types for the 2-D gradient noise block.
// No dependencies; the interfaces, the fade unit and the top module import this package.
`timescale 1ns / 1ps
`default_nettype none

package pn2d_pkg;

   // fixed-point and table geometry
   localparam int FRAC_BITS  = 16;
   localparam int TABLE_SIZE = 256;
   localparam int TBL_AW     = $clog2(TABLE_SIZE);
   localparam int ENTRY_W    = 8;
   localparam int IDX_W      = 8;
   localparam int COORD_W    = 24;
   localparam int OUT_W      = 16;
   localparam int FADE_W     = FRAC_BITS + 1;

   // action codes carried by an input word
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_EVAL  = 1'b1;

   typedef logic [FRAC_BITS-1:0] frac_type;
   typedef logic [FADE_W-1:0]    fade_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pn2d_req_if.sv =====
// Request channel of the noise block: valid/ready plus one input word.
// Depends on pn2d_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pn2d_req_if;
   import pn2d_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [IDX_W-1:0]     table_index;
   logic [ENTRY_W-1:0]   table_value;
   logic [COORD_W-1:0]   x_coord;
   logic [COORD_W-1:0]   y_coord;

   modport source (
      output valid, action, table_index, table_value, x_coord, y_coord,
      input  ready
   );

   modport sink (
      input  valid, action, table_index, table_value, x_coord, y_coord,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/pn2d_rsp_if.sv =====
// Response channel of the noise block: valid/ready plus one noise word.
// Depends on pn2d_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface pn2d_rsp_if;
   import pn2d_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] noise_value;

   modport source (
      output valid, noise_value,
      input  ready
   );

   modport sink (
      input  valid, noise_value,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/pn2d_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// A read at the address written in the same cycle returns the old data.
`timescale 1ns / 1ps
`default_nettype none

module pn2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read ports, read-first
   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pn2d_fade.sv =====
// Pipelined fade curve 6t^5-15t^4+10t^3 in fixed point, with registered stages.
// Depends on pn2d_pkg for the fraction and fade widths.
`timescale 1ns / 1ps
`default_nettype none

module pn2d_fade (
   input  logic               clock,
   input  pn2d_pkg::frac_type frac_in,
   output pn2d_pkg::fade_type fade_out
);
   import pn2d_pkg::*;

   localparam int K_W  = FRAC_BITS + 4;          // holds up to 15.0
   localparam int PB_W = FRAC_BITS + K_W;        // t * (15 - 6t)
   localparam int SQ_W = 2 * FRAC_BITS;          // t * t
   localparam int CU_W = FADE_W + FRAC_BITS;     // t^2 * t
   localparam int PU_W = FADE_W + K_W;           // t^3 * c

   localparam logic [K_W-1:0]    K15     = K_W'(15) << FRAC_BITS;
   localparam logic [K_W-1:0]    K10     = K_W'(10) << FRAC_BITS;
   localparam logic [PB_W-1:0]   HALF_PB = PB_W'(1) << (FRAC_BITS - 1);
   localparam logic [SQ_W-1:0]   HALF_SQ = SQ_W'(1) << (FRAC_BITS - 1);
   localparam logic [CU_W-1:0]   HALF_CU = CU_W'(1) << (FRAC_BITS - 1);
   localparam logic [PU_W-1:0]   HALF_PU = PU_W'(1) << (FRAC_BITS - 1);
   localparam logic [PU_W-1:0]   ONE_PU  = PU_W'(1) << FRAC_BITS;
   localparam logic [FADE_W-1:0] ONE_F   = FADE_W'(1) << FRAC_BITS;

   logic [K_W-1:0]    kb_w;
   logic [PB_W-1:0]   pb_ff;
   logic [SQ_W-1:0]   sq_ff;
   frac_type          f1_ff;
   logic [PB_W-1:0]   b_rnd_w;
   logic [SQ_W-1:0]   sq_rnd_w;
   logic [K_W-1:0]    c_ff;
   logic [CU_W-1:0]   cu_ff;
   logic [CU_W-1:0]   cu_rnd_w;
   logic [PU_W-1:0]   pu_ff;
   logic [PU_W-1:0]   pu_rnd_w;
   fade_type          fade_ff;

   // stage 1: t*(15-6t) and t*t
   assign kb_w = K15 - (K_W'(frac_in) << 2) - (K_W'(frac_in) << 1);

   always_ff @(posedge clock) begin
      pb_ff <= PB_W'(frac_in) * PB_W'(kb_w);
      sq_ff <= SQ_W'(frac_in) * SQ_W'(frac_in);
      f1_ff <= frac_in;
   end

   // stage 2: c = 10 - round(t*(15-6t)), t^3 product
   assign b_rnd_w  = (pb_ff + HALF_PB) >> FRAC_BITS;
   assign sq_rnd_w = (sq_ff + HALF_SQ) >> FRAC_BITS;

   always_ff @(posedge clock) begin
      c_ff  <= K10 - b_rnd_w[K_W-1:0];
      cu_ff <= CU_W'(sq_rnd_w[FADE_W-1:0]) * CU_W'(f1_ff);
   end

   // stage 3: t^3 * c
   assign cu_rnd_w = (cu_ff + HALF_CU) >> FRAC_BITS;

   always_ff @(posedge clock) begin
      pu_ff <= PU_W'(cu_rnd_w[FADE_W-1:0]) * PU_W'(c_ff);
   end

   // stage 4: round and clamp to 1.0
   assign pu_rnd_w = (pu_ff + HALF_PU) >> FRAC_BITS;

   always_ff @(posedge clock) begin
      fade_ff <= (pu_rnd_w > ONE_PU) ? ONE_F : pu_rnd_w[FADE_W-1:0];
   end

   assign fade_out = fade_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/perlin_noise_2d.sv =====
// 2-D improved gradient noise. A write word (action 0) stores one byte of the
// 256-entry permutation table; an evaluate word (action 1) takes a Q8.16
// point and returns one 16-bit noise word, (n+1)/2 saturated. The table is
// held in three identical RAM copies, written together, each with two read
// ports: one copy hashes the two x corners, the other two hash the four cell
// corners a cycle later, so six lookups fit in every clock and no clearing
// pass runs after reset (entries must be written before they are read). The
// datapath is a free-running pipeline that ends in a result queue ahead of
// rsp_chan, and the block takes one word per clock while req_chan.ready is
// high. Results wait in a RSP_DEPTH-entry queue; req_chan.ready drops only in
// reset or while RSP_DEPTH evaluate words are accepted and not yet taken, so
// with RSP_DEPTH of ten or more a consumer that is always ready sees one
// result per clock. A write word takes effect for every later evaluate word.
`timescale 1ns / 1ps
`default_nettype none

module perlin_noise_2d #(
   parameter int RSP_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   pn2d_req_if.sink   req_chan,
   pn2d_rsp_if.source rsp_chan
);
   import pn2d_pkg::*;

   localparam int PTR_W     = $clog2(RSP_DEPTH);
   localparam int CNT_W     = $clog2(RSP_DEPTH + 1);
   localparam int PIPE_LAT  = 8;                     // accept to queue write
   localparam int GRAD_W    = FRAC_BITS + 3;
   localparam int DIFF_W    = FRAC_BITS + 4;
   localparam int PB_W      = FADE_W + 1 + DIFF_W;
   localparam int LX_W      = FRAC_BITS + 4;
   localparam int LD_W      = LX_W + 1;
   localparam int PN_W      = FADE_W + 1 + LD_W;
   localparam int N_W       = LD_W;
   localparam int SH_W      = N_W - 1;
   localparam int OUT_SHIFT = FRAC_BITS + 1 - OUT_W;

   // corner order in the gradient pipeline
   localparam int C_AA = 0;
   localparam int C_BA = 1;
   localparam int C_AB = 2;
   localparam int C_BB = 3;

   localparam logic signed [GRAD_W-1:0] ONE_G   = GRAD_W'(1) << FRAC_BITS;
   localparam logic signed [PB_W-1:0]   HALF_PB = PB_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [PN_W-1:0]   HALF_PN = PN_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [N_W-1:0]    ONE_N   = N_W'(1) << FRAC_BITS;
   localparam logic [SH_W-1:0]          OUT_MAX = SH_W'(2 ** OUT_W - 1);

   // gradient pick from the low three hash bits
   function automatic logic signed [GRAD_W-1:0] grad_sel(
      input logic [2:0]               hsel,
      input logic signed [GRAD_W-1:0] dx,
      input logic signed [GRAD_W-1:0] dy
   );
      logic signed [GRAD_W-1:0] first_v;
      logic signed [GRAD_W-1:0] second_v;
      first_v  = hsel[2] ? dy : dx;
      second_v = hsel[2] ? dx : dy;
      if (hsel[0]) begin
         first_v = -first_v;
      end
      if (hsel[1]) begin
         second_v = -second_v;
      end
      return first_v + second_v;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(RSP_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   // handshake
   logic req_acc_w;
   logic eval_acc_w;
   logic wr_acc_w;
   logic push_w;
   logic pop_w;

   // pipeline valid chain
   logic [PIPE_LAT-1:0] vld_ff;

   // stage 1 / 2 payload
   frac_type          fx1_ff;
   frac_type          fy1_ff;
   logic [TBL_AW-1:0] cy1_ff;
   frac_type          fx2_ff;
   frac_type          fy2_ff;

   // table lookups
   logic [TBL_AW-1:0]  cx_w;
   logic [ENTRY_W-1:0] px0_w;
   logic [ENTRY_W-1:0] px1_w;
   logic [TBL_AW-1:0]  ha0_w;
   logic [TBL_AW-1:0]  ha1_w;
   logic [TBL_AW-1:0]  hb0_w;
   logic [TBL_AW-1:0]  hb1_w;
   logic [ENTRY_W-1:0] aa_w;
   logic [ENTRY_W-1:0] ab_w;
   logic [ENTRY_W-1:0] ba_w;
   logic [ENTRY_W-1:0] bb_w;

   // gradients and blends
   logic signed [GRAD_W-1:0] dx0_w;
   logic signed [GRAD_W-1:0] dx1_w;
   logic signed [GRAD_W-1:0] dy0_w;
   logic signed [GRAD_W-1:0] dy1_w;
   logic signed [GRAD_W-1:0] g3_ff [4];
   logic signed [GRAD_W-1:0] g4_ff [4];
   logic signed [GRAD_W-1:0] g5_ff [4];
   fade_type                 ux_w;
   fade_type                 uy_w;
   logic signed [FADE_W:0]   ux_s_w;
   logic signed [DIFF_W-1:0] diff0_w;
   logic signed [DIFF_W-1:0] diff1_w;
   logic signed [PB_W-1:0]   pb0_ff;
   logic signed [PB_W-1:0]   pb1_ff;
   logic signed [GRAD_W-1:0] ga6_ff;
   logic signed [GRAD_W-1:0] gb6_ff;
   fade_type                 v6_ff;
   logic signed [PB_W-1:0]   pb0_rnd_w;
   logic signed [PB_W-1:0]   pb1_rnd_w;
   logic signed [LX_W-1:0]   lx0_ff;
   logic signed [LX_W-1:0]   lx1_ff;
   fade_type                 v7_ff;
   logic signed [FADE_W:0]   vs_w;
   logic signed [LD_W-1:0]   ldiff_w;
   logic signed [PN_W-1:0]   pn_ff;
   logic signed [LX_W-1:0]   lx8_ff;
   logic signed [PN_W-1:0]   pn_rnd_w;
   logic signed [N_W-1:0]    n_w;
   logic signed [N_W-1:0]    val_w;
   logic [SH_W-1:0]          sh_w;
   logic [OUT_W-1:0]         noise_w;

   // result queue
   logic [OUT_W-1:0] fifo_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] fifo_cnt_ff;
   logic [CNT_W-1:0] fifo_cnt_in;
   logic [CNT_W-1:0] out_cnt_ff;
   logic [CNT_W-1:0] out_cnt_in;

   // ------------------------------------------------------------------
   // handshake: ready while the queue can still absorb every open word
   assign req_chan.ready = ~reset & (out_cnt_ff < CNT_W'(RSP_DEPTH));
   assign req_acc_w      = req_chan.valid & req_chan.ready;
   assign eval_acc_w     = req_acc_w & (req_chan.action == ACT_EVAL);
   assign wr_acc_w       = req_acc_w & (req_chan.action == ACT_WRITE);
   assign push_w         = vld_ff[PIPE_LAT-1];
   assign pop_w          = rsp_chan.valid & rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], eval_acc_w};
      end
   end

   // ------------------------------------------------------------------
   // stage 0: x corner lookups straight from the request word
   assign cx_w = req_chan.x_coord[FRAC_BITS +: TBL_AW];

   pn2d_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_ram_x (
      .clock     (clock),
      .wr_en     (wr_acc_w),
      .wr_addr   (req_chan.table_index[TBL_AW-1:0]),
      .wr_data   (req_chan.table_value),
      .rd_addr_a (cx_w),
      .rd_addr_b (cx_w + TBL_AW'(1)),
      .rd_data_a (px0_w),
      .rd_data_b (px1_w)
   );

   always_ff @(posedge clock) begin
      fx1_ff <= req_chan.x_coord[FRAC_BITS-1:0];
      fy1_ff <= req_chan.y_coord[FRAC_BITS-1:0];
      cy1_ff <= req_chan.y_coord[FRAC_BITS +: TBL_AW];
   end

   // ------------------------------------------------------------------
   // stage 1: four corner hashes; a write in this same cycle is not seen
   assign ha0_w = TBL_AW'(px0_w) + cy1_ff;
   assign ha1_w = ha0_w + TBL_AW'(1);
   assign hb0_w = TBL_AW'(px1_w) + cy1_ff;
   assign hb1_w = hb0_w + TBL_AW'(1);

   pn2d_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_ram_a (
      .clock     (clock),
      .wr_en     (wr_acc_w),
      .wr_addr   (req_chan.table_index[TBL_AW-1:0]),
      .wr_data   (req_chan.table_value),
      .rd_addr_a (ha0_w),
      .rd_addr_b (ha1_w),
      .rd_data_a (aa_w),
      .rd_data_b (ab_w)
   );

   pn2d_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_ram_b (
      .clock     (clock),
      .wr_en     (wr_acc_w),
      .wr_addr   (req_chan.table_index[TBL_AW-1:0]),
      .wr_data   (req_chan.table_value),
      .rd_addr_a (hb0_w),
      .rd_addr_b (hb1_w),
      .rd_data_a (ba_w),
      .rd_data_b (bb_w)
   );

   always_ff @(posedge clock) begin
      fx2_ff <= fx1_ff;
      fy2_ff <= fy1_ff;
   end

   // fade weights, ready at stage 5
   pn2d_fade u_fade_x (
      .clock    (clock),
      .frac_in  (fx1_ff),
      .fade_out (ux_w)
   );

   pn2d_fade u_fade_y (
      .clock    (clock),
      .frac_in  (fy1_ff),
      .fade_out (uy_w)
   );

   // ------------------------------------------------------------------
   // stage 2: corner gradients, then carried along until the fades land
   assign dx0_w = $signed(GRAD_W'(fx2_ff));
   assign dy0_w = $signed(GRAD_W'(fy2_ff));
   assign dx1_w = dx0_w - ONE_G;
   assign dy1_w = dy0_w - ONE_G;

   always_ff @(posedge clock) begin
      g3_ff[C_AA] <= grad_sel(aa_w[2:0], dx0_w, dy0_w);
      g3_ff[C_BA] <= grad_sel(ba_w[2:0], dx1_w, dy0_w);
      g3_ff[C_AB] <= grad_sel(ab_w[2:0], dx0_w, dy1_w);
      g3_ff[C_BB] <= grad_sel(bb_w[2:0], dx1_w, dy1_w);
      g4_ff       <= g3_ff;
      g5_ff       <= g4_ff;
   end

   // ------------------------------------------------------------------
   // stage 5: x blend products
   assign ux_s_w  = $signed({1'b0, ux_w});
   assign diff0_w = DIFF_W'(g5_ff[C_BA]) - DIFF_W'(g5_ff[C_AA]);
   assign diff1_w = DIFF_W'(g5_ff[C_BB]) - DIFF_W'(g5_ff[C_AB]);

   always_ff @(posedge clock) begin
      pb0_ff <= PB_W'(ux_s_w) * PB_W'(diff0_w);
      pb1_ff <= PB_W'(ux_s_w) * PB_W'(diff1_w);
      ga6_ff <= g5_ff[C_AA];
      gb6_ff <= g5_ff[C_AB];
      v6_ff  <= uy_w;
   end

   // stage 6: finish x blends (round half up)
   assign pb0_rnd_w = (pb0_ff + HALF_PB) >>> FRAC_BITS;
   assign pb1_rnd_w = (pb1_ff + HALF_PB) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      lx0_ff <= LX_W'(ga6_ff) + $signed(pb0_rnd_w[LX_W-1:0]);
      lx1_ff <= LX_W'(gb6_ff) + $signed(pb1_rnd_w[LX_W-1:0]);
      v7_ff  <= v6_ff;
   end

   // stage 7: y blend product
   assign vs_w    = $signed({1'b0, v7_ff});
   assign ldiff_w = LD_W'(lx1_ff) - LD_W'(lx0_ff);

   always_ff @(posedge clock) begin
      pn_ff  <= PN_W'(vs_w) * PN_W'(ldiff_w);
      lx8_ff <= lx0_ff;
   end

   // stage 8: final blend, shift into [0,1) and saturate
   assign pn_rnd_w = (pn_ff + HALF_PN) >>> FRAC_BITS;
   assign n_w      = N_W'(lx8_ff) + $signed(pn_rnd_w[N_W-1:0]);
   assign val_w    = n_w + ONE_N;
   assign sh_w     = val_w[N_W-2:0] >> OUT_SHIFT;

   always_comb begin
      if (val_w[N_W-1]) begin
         noise_w = '0;
      end else if (sh_w > OUT_MAX) begin
         noise_w = '1;
      end else begin
         noise_w = sh_w[OUT_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // result queue
   always_ff @(posedge clock) begin
      if (push_w) begin
         fifo_ff[wr_ptr_ff] <= noise_w;
      end
   end

   always_comb begin
      wr_ptr_in   = push_w ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in   = pop_w ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      fifo_cnt_in = fifo_cnt_ff + CNT_W'(push_w) - CNT_W'(pop_w);
      out_cnt_in  = out_cnt_ff + CNT_W'(eval_acc_w) - CNT_W'(pop_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         out_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fifo_cnt_ff <= fifo_cnt_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   assign rsp_chan.valid       = (fifo_cnt_ff != '0);
   assign rsp_chan.noise_value = fifo_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   // every queue write traces back to an evaluate word that has passed the whole valid chain
   a_push_latency: assert property (@(posedge clock) disable iff (reset)
      push_w |-> $past(eval_acc_w, PIPE_LAT))
      else $error("queue write without matching evaluate word");

   // credit scheme keeps a slot free for each word in flight
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      push_w |-> (fifo_cnt_ff < CNT_W'(RSP_DEPTH)))
      else $error("result queue overflow");

   // open words are exactly those in the pipeline plus those queued
   a_open_count: assert property (@(posedge clock) disable iff (reset)
      int'(out_cnt_ff) == int'(fifo_cnt_ff) + $countones(vld_ff))
      else $error("open word count out of step with pipeline and queue");

   a_open_max: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= CNT_W'(RSP_DEPTH))
      else $error("open word count above queue depth");
`endif

endmodule

`default_nettype wire
